>>> rtl/core/dd_odo_pkg.sv
// ----------------------------------------------------------------------------
// dd_odo_pkg
// Shared types, constants and elaboration helpers for the wheel odometry core.
// ----------------------------------------------------------------------------
`default_nettype none

package dd_odo_pkg;

    // Rotation vector width: Q30 unit vector plus headroom, Q30 angle plus sign
    localparam int VEC_W = 34;

    // pi in Q60
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int ATAN_DEPTH          = 24;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } cordic_vec_t;

    // atan(2^-i) in Q30, rounded
    localparam logic [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    // floor(sqrt(2^60 * prod(1 + 2^-2i))), the Q30 CORDIC magnitude growth
    function automatic logic [63:0] cordic_growth(input int steps);
        logic [63:0] prod;
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        prod = 64'd1 << 60;
        for (int i = 0; i < ATAN_DEPTH; i++)
        begin
            if (i < steps)
            begin
                prod = prod + (prod >> (2 * i));
            end
        end
        rem  = prod;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (bitv > rem)
            begin
                bitv = bitv >> 2;
            end
        end
        for (int j = 0; j < 32; j++)
        begin
            if (bitv != 64'd0)
            begin
                if (rem >= res + bitv)
                begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: encoder deltas in, saturated pose out.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per sample, right/left encoder deltas.
// Output stream m_*: one request per sample, the new pose (x, y, heading).
// APB port: meters_per_tick, inv_wheel_base, polarities and start pose at
// byte addresses 0x00..0x18. Writing a start register loads that pose part.
// Path: the multiply steps, the mid-step angle, the CORDIC cell row, the
// position multiply and the update; one sample is in flight at a time, so
// a new sample is taken only once the last one has left S_UPD.
// The finished pose sits in an output register, so the next sample is taken
// while it waits; its own update then holds until the output is taken.
// A start_heading write wraps the value into [-pi, pi] by binary reduction
// in S_WRAP; no sample is taken then.
// Reset clears the state, configuration and the pose to zero; the payload registers have no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry #(
    parameter int CORDIC_STEPS    = dd_odo_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = dd_odo_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,     // right_delta[15:0], left_delta[31:16]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,     // pos_x[31:0], pos_y[63:32], heading_out[82:64]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dd_odo_pkg::*;

    localparam int HW  = ANGLE_FRAC_BITS + 3;
    localparam int RK  = 24 - ANGLE_FRAC_BITS;
    localparam int WRW = (HW + 1 > 20) ? HW + 1 : 20;
    localparam int WRAP_STEPS = (ANGLE_FRAC_BITS <= 16) ? 17 - ANGLE_FRAC_BITS : 1;
    localparam int KW  = (WRAP_STEPS > 1) ? $clog2(WRAP_STEPS) : 1;
    localparam logic [63:0] PI_A64 =
        (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic signed [HW:0]    PI_H  = PI_A64[HW:0];
    localparam logic signed [HW:0]    TPI_H = PI_H <<< 1;
    localparam logic [WRW-1:0]        PI_W  = WRW'(PI_A64);
    localparam logic [WRW-1:0]        TPI_W = WRW'(PI_A64 << 1);
    localparam logic [50:0]           PI_Q  = 51'(PI_A64);

    localparam logic [2:0] REG_MPT  = 3'd0;
    localparam logic [2:0] REG_IWB  = 3'd1;
    localparam logic [2:0] REG_RPOL = 3'd2;
    localparam logic [2:0] REG_LPOL = 3'd3;
    localparam logic [2:0] REG_SX   = 3'd4;
    localparam logic [2:0] REG_SY   = 3'd5;
    localparam logic [2:0] REG_SH   = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_MUL_A, S_MUL_B, S_DTH, S_MID, S_CORDIC, S_MUL_P, S_UPD
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0]        mpt_reg;
    logic [23:0]        iwb_reg;
    logic               rpol_reg;
    logic               lpol_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic signed [18:0] sh_reg;
    logic               wr_en;
    logic [2:0]         wr_idx;

    // pose
    logic signed [31:0]   pose_x_reg;
    logic signed [31:0]   pose_y_reg;
    logic signed [HW-1:0] pose_h_reg;

    // heading wrap on load
    logic [WRW-1:0]        wrap_a_reg;
    logic                  wrap_neg_reg;
    logic [KW-1:0]         wrap_k_reg;
    logic [WRW-1:0]        wrap_sub;
    logic [WRW-1:0]        wrap_red;
    logic signed [WRW-1:0] wrap_fold;
    logic signed [WRW-1:0] wrap_res;

    // datapath
    logic signed [16:0] r_in;
    logic signed [16:0] l_in;
    logic signed [17:0] sum_next;
    logic signed [17:0] diff_next;
    logic signed [17:0] sum_reg;
    logic [16:0]        mag_reg;
    logic               neg_reg;
    logic signed [50:0] dprod_reg;
    logic [48:0]        m_reg;
    logic signed [32:0] d_reg;
    logic [48:0]        hi_reg;
    logic [47:0]        lo_reg;
    logic [49:0]        t_sum;
    logic [50:0]        q_val;
    logic               rbit;
    logic signed [HW-1:0] dth_next;
    logic signed [HW:0]   mid_reg;
    logic signed [HW:0]   hsum_reg;
    logic signed [HW-1:0] h_wrapped;
    logic signed [51:0]   dround;

    // CORDIC
    logic                      cordic_start;
    logic                      cordic_done;
    logic signed [VEC_W-1:0]   cos_w;
    logic signed [VEC_W-1:0]   sin_w;
    logic signed [VEC_W-1:0]   cos_reg;
    logic signed [VEC_W-1:0]   sin_reg;
    logic signed [66:0]        px_reg;
    logic signed [66:0]        py_reg;
    logic signed [36:0]        step_x;
    logic signed [36:0]        step_y;
    logic signed [37:0]        new_x;
    logic signed [37:0]        new_y;
    logic signed [31:0]        sat_x;
    logic signed [31:0]        sat_y;

    // output
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic [18:0]        out_h_reg;
    logic signed [HW+18:0] h_ext;
    logic               out_free;

    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[4:2];
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MPT:  prdata = mpt_reg;
            REG_IWB:  prdata = {8'd0, iwb_reg};
            REG_RPOL: prdata = {31'd0, rpol_reg};
            REG_LPOL: prdata = {31'd0, lpol_reg};
            REG_SX:   prdata = sx_reg;
            REG_SY:   prdata = sy_reg;
            REG_SH:   prdata = {{13{sh_reg[18]}}, sh_reg};
            default:  prdata = 32'd0;
        endcase
    end

    // input conditioning
    assign r_in      = rpol_reg ? -17'(signed'(s_tdata[15:0])) : 17'(signed'(s_tdata[15:0]));
    assign l_in      = lpol_reg ? -17'(signed'(s_tdata[31:16])) : 17'(signed'(s_tdata[31:16]));
    assign sum_next  = 18'(r_in) + 18'(l_in);
    assign diff_next = 18'(r_in) - 18'(l_in);

    // heading change: round(|diff| * mpt * iwb / 2^(48 - AFB)), capped at pi
    assign t_sum = 50'(hi_reg) + 50'(lo_reg[47:24]);
    if (RK > 0)
    begin : g_rk
        assign rbit = t_sum[RK-1];
    end
    else
    begin : g_rk0
        assign rbit = lo_reg[23];
    end
    always_comb
    begin
        q_val = 51'(t_sum >> RK) + 51'(rbit);
        if (q_val > PI_Q)
        begin
            q_val = PI_Q;
        end
        dth_next = neg_reg ? -HW'(q_val) : HW'(q_val);
    end

    assign dround = 52'(dprod_reg) + 52'sd65536;

    // pose update
    assign step_x = 37'((px_reg + 67'sd536870912) >>> 30);
    assign step_y = 37'((py_reg + 67'sd536870912) >>> 30);
    assign new_x  = 38'(pose_x_reg) + 38'(step_x);
    assign new_y  = 38'(pose_y_reg) + 38'(step_y);

    always_comb
    begin
        priority if (new_x > 38'sd2147483647)
            sat_x = 32'sh7FFFFFFF;
        else if (new_x < -38'sd2147483648)
            sat_x = 32'sh80000000;
        else
            sat_x = new_x[31:0];
        priority if (new_y > 38'sd2147483647)
            sat_y = 32'sh7FFFFFFF;
        else if (new_y < -38'sd2147483648)
            sat_y = 32'sh80000000;
        else
            sat_y = new_y[31:0];
        priority if (hsum_reg > PI_H)
            h_wrapped = HW'(hsum_reg - TPI_H);
        else if (hsum_reg < -PI_H)
            h_wrapped = HW'(hsum_reg + TPI_H);
        else
            h_wrapped = HW'(hsum_reg);
    end

    assign h_ext = (HW + 19)'(h_wrapped);

    // start heading wrap: binary reduction mod 2*pi on the magnitude, then fold
    assign wrap_sub = TPI_W << wrap_k_reg;
    always_comb
    begin
        wrap_red = (wrap_a_reg >= wrap_sub) ? wrap_a_reg - wrap_sub : wrap_a_reg;
        if (wrap_red > PI_W)
            wrap_fold = signed'(wrap_red - TPI_W);
        else
            wrap_fold = signed'(wrap_red);
        wrap_res = wrap_neg_reg ? -wrap_fold : wrap_fold;
    end

    assign out_free     = !out_valid_reg || m_tready;
    assign cordic_start = (state_reg == S_MID);

    dd_odo_cordic #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (mid_reg),
        .done    (cordic_done),
        .cos_out (cos_w),
        .sin_out (sin_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mpt_reg       <= '0;
            iwb_reg       <= '0;
            rpol_reg      <= 1'b0;
            lpol_reg      <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sh_reg        <= '0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_h_reg    <= '0;
            out_valid_reg <= 1'b0;
            wrap_a_reg    <= '0;
            wrap_neg_reg  <= 1'b0;
            wrap_k_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_UPD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_MUL_A;
                    end
                end
                S_WRAP:
                begin
                    wrap_a_reg <= wrap_red;
                    wrap_k_reg <= wrap_k_reg - KW'(1);
                    if (wrap_k_reg == '0)
                    begin
                        pose_h_reg <= HW'(wrap_res);
                        state_reg  <= S_IDLE;
                    end
                end
                S_MUL_A:  state_reg <= S_MUL_B;
                S_MUL_B:  state_reg <= S_DTH;
                S_DTH:    state_reg <= S_MID;
                S_MID:    state_reg <= S_CORDIC;
                S_CORDIC:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= S_MUL_P;
                    end
                end
                S_MUL_P:  state_reg <= S_UPD;
                S_UPD:
                begin
                    if (out_free)
                    begin
                        pose_x_reg    <= sat_x;
                        pose_y_reg    <= sat_y;
                        pose_h_reg    <= h_wrapped;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
            if (wr_en)
            begin
                unique case (wr_idx)
                    REG_MPT:  mpt_reg  <= pwdata;
                    REG_IWB:  iwb_reg  <= pwdata[23:0];
                    REG_RPOL: rpol_reg <= pwdata[0];
                    REG_LPOL: lpol_reg <= pwdata[0];
                    REG_SX:
                    begin
                        sx_reg     <= pwdata;
                        pose_x_reg <= pwdata;
                    end
                    REG_SY:
                    begin
                        sy_reg     <= pwdata;
                        pose_y_reg <= pwdata;
                    end
                    REG_SH:
                    begin
                        sh_reg       <= pwdata[18:0];
                        // magnitude taken at 19 bits, then widened
                        wrap_a_reg   <= WRW'(19'(pwdata[18] ? -pwdata[18:0] : pwdata[18:0]));
                        wrap_neg_reg <= pwdata[18];
                        wrap_k_reg   <= KW'(WRAP_STEPS - 1);
                        state_reg    <= S_WRAP;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            sum_reg <= sum_next;
            mag_reg <= diff_next[17] ? 17'(-diff_next) : 17'(diff_next);
            neg_reg <= diff_next[17];
        end
        if (state_reg == S_MUL_A)
        begin
            dprod_reg <= 51'(sum_reg) * 51'(signed'({1'b0, mpt_reg}));
            m_reg     <= 49'(mag_reg) * 49'(mpt_reg);
        end
        if (state_reg == S_MUL_B)
        begin
            d_reg  <= 33'(dround >>> 17);
            hi_reg <= 49'(m_reg[48:24]) * 49'(iwb_reg);
            lo_reg <= 48'(m_reg[23:0]) * 48'(iwb_reg);
        end
        // mid-step angle is ready for the CORDIC load in S_MID
        if (state_reg == S_DTH)
        begin
            mid_reg  <= (HW + 1)'(pose_h_reg) + (HW + 1)'(dth_next >>> 1);
            hsum_reg <= (HW + 1)'(pose_h_reg) + (HW + 1)'(dth_next);
        end
        if (state_reg == S_CORDIC && cordic_done)
        begin
            cos_reg <= cos_w;
            sin_reg <= sin_w;
        end
        if (state_reg == S_MUL_P)
        begin
            px_reg <= 67'(d_reg) * 67'(cos_reg);
            py_reg <= 67'(d_reg) * 67'(sin_reg);
        end
        if (state_reg == S_UPD && out_free)
        begin
            out_x_reg <= sat_x;
            out_y_reg <= sat_y;
            out_h_reg <= h_ext[18:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_h_reg, out_y_reg, out_x_reg};

endmodule

`default_nettype wire

>>> rtl/core/dd_odo_cordic_cell.sv
// ----------------------------------------------------------------------------
// dd_odo_cordic_cell
// One rotation-mode CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_odo_cordic_cell #(
    parameter int          SHIFT = 0,
    parameter logic [31:0] ATAN  = 32'd0
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    input  dd_odo_pkg::cordic_vec_t   in_vec,
    output logic                      out_valid,
    output dd_odo_pkg::cordic_vec_t   out_vec
);
    import dd_odo_pkg::*;

    localparam logic signed [VEC_W-1:0] ANG = VEC_W'(ATAN);

    logic        valid_reg;
    cordic_vec_t vec_reg;
    cordic_vec_t vec_next;

    always_comb
    begin
        if (!in_vec.z[VEC_W-1])
        begin
            vec_next.x = in_vec.x - (in_vec.y >>> SHIFT);
            vec_next.y = in_vec.y + (in_vec.x >>> SHIFT);
            vec_next.z = in_vec.z - ANG;
        end
        else
        begin
            vec_next.x = in_vec.x + (in_vec.y >>> SHIFT);
            vec_next.y = in_vec.y - (in_vec.x >>> SHIFT);
            vec_next.z = in_vec.z + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

>>> rtl/core/dd_odo_cordic.sv
// ----------------------------------------------------------------------------
// dd_odo_cordic
// Quadrant fold plus a row of CORDIC cells giving cos and sin in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_odo_cordic #(
    parameter int CORDIC_STEPS    = dd_odo_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = dd_odo_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        start,
    input  wire signed [ANGLE_FRAC_BITS+3:0]           angle,
    output logic                                       done,
    output logic signed [dd_odo_pkg::VEC_W-1:0]        cos_out,
    output logic signed [dd_odo_pkg::VEC_W-1:0]        sin_out
);
    import dd_odo_pkg::*;

    localparam int          ZW      = 35;
    localparam logic [63:0] GROWTH  = cordic_growth(CORDIC_STEPS);
    localparam logic [63:0] GAIN    = ((64'd1 << 60) + GROWTH / 64'd2) / GROWTH;
    localparam logic [63:0] PI30_64 = (PI_Q60 + (64'd1 << 29)) >> 30;
    localparam logic signed [ZW-1:0] PI30   = ZW'(PI30_64);
    localparam logic signed [ZW-1:0] HALF30 = ZW'(PI30_64 >> 1);

    logic signed [ZW-1:0] z_scaled;
    logic signed [ZW-1:0] z_fold;
    logic                 flip_next;
    logic                 flip_reg;
    logic                 load_reg;
    cordic_vec_t          load_vec_reg;

    cordic_vec_t          chain_vec   [CORDIC_STEPS+1];
    logic                 chain_valid [CORDIC_STEPS+1];

    assign z_scaled = ZW'(angle) <<< (30 - ANGLE_FRAC_BITS);

    always_comb
    begin
        priority if (z_scaled > HALF30)
        begin
            z_fold    = z_scaled - PI30;
            flip_next = 1'b1;
        end
        else if (z_scaled < -HALF30)
        begin
            z_fold    = z_scaled + PI30;
            flip_next = 1'b1;
        end
        else
        begin
            z_fold    = z_scaled;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            flip_reg <= 1'b0;
        end
        else
        begin
            load_reg <= start;
            if (start)
            begin
                flip_reg <= flip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            load_vec_reg.x <= VEC_W'(GAIN);
            load_vec_reg.y <= '0;
            load_vec_reg.z <= VEC_W'(z_fold);
        end
    end

    assign chain_vec[0]   = load_vec_reg;
    assign chain_valid[0] = load_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        dd_odo_cordic_cell #(
            .SHIFT (g),
            .ATAN  (ATAN_Q30[g])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_vec    (chain_vec[g]),
            .out_valid (chain_valid[g+1]),
            .out_vec   (chain_vec[g+1])
        );
    end

    assign done    = chain_valid[CORDIC_STEPS];
    assign cos_out = flip_reg ? -chain_vec[CORDIC_STEPS].x : chain_vec[CORDIC_STEPS].x;
    assign sin_out = flip_reg ? -chain_vec[CORDIC_STEPS].y : chain_vec[CORDIC_STEPS].y;

endmodule

`default_nettype wire

>>> tb/tb_diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry
// Self-checking bench for the wheel odometry core. A directed table covers
// reset values, field extremes, start heading wrap and position saturation;
// randomized phases with varied calibration then run against a bit-true
// pose predictor while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_diff_drive_odometry;

    import dd_odo_pkg::*;

    typedef enum int {
        REG_METERS_PER_TICK = 0,
        REG_INV_WHEEL_BASE  = 1,
        REG_RIGHT_POLARITY  = 2,
        REG_LEFT_POLARITY   = 3,
        REG_START_X         = 4,
        REG_START_Y         = 5,
        REG_START_HEADING   = 6
    } odo_reg_e;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [18:0]        h;
    } pose_t;

    typedef struct {
        bit          wr;
        odo_reg_e    idx;
        logic [31:0] val;
        shortint     r;
        shortint     l;
        bit          typed;
        pose_t       pose;
    } odo_row_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 235;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    diff_drive_odometry i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [31:0]        cal_mpt;
    logic [23:0]        cal_iwb;
    bit                 cal_rpol;
    bit                 cal_lpol;
    longint             pose_x;
    longint             pose_y;
    longint             pose_h;
    longint             growth_q30;
    longint             pi_ang;
    longint             pi_q30;

    pose_t              pose_q[$];
    int                 errors = 0;
    int                 samples_sent = 0;
    int                 poses_seen = 0;
    int                 idle_cycles = 0;

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic longint wrap_heading(longint h);
        while (h > pi_ang)
        begin
            h = h - 2 * pi_ang;
        end
        while (h < -pi_ang)
        begin
            h = h + 2 * pi_ang;
        end
        return h;
    endfunction

    function automatic void init_math();
        longint unsigned prod;
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        prod = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            prod = prod + (prod >> (2 * i));
        end
        rem  = prod;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        growth_q30 = longint'(((64'd1 << 60) + res / 2) / res);
        pi_ang = longint'((PI_Q60 + (64'd1 << 43)) >> 44);
        pi_q30 = longint'((PI_Q60 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint xn;
        bit     flip;
        z = ang * (64'sd1 <<< 14);
        x = growth_q30;
        y = 0;
        flip = 0;
        if (z > pi_q30 / 2)
        begin
            z = z - pi_q30;
            flip = 1;
        end
        else if (z < -(pi_q30 / 2))
        begin
            z = z + pi_q30;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_Q30[i]);
            end
            else
            begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_Q30[i]);
            end
            x = xn;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic pose_t odo_predict(shortint rd, shortint ld);
        longint          r;
        longint          l;
        longint          sum;
        longint          diff;
        longint          d;
        longint          dth;
        longint          c;
        longint          s;
        longint unsigned m;
        longint unsigned t;
        longint unsigned lo;
        longint unsigned q;
        pose_t           p;
        r = cal_rpol ? -longint'(rd) : longint'(rd);
        l = cal_lpol ? -longint'(ld) : longint'(ld);
        sum  = r + l;
        diff = r - l;
        d = (sum * longint'({32'd0, cal_mpt}) + (64'sd1 <<< 16)) >>> 17;
        // heading change on the magnitude, round half away from zero
        m  = longint'(diff < 0 ? -diff : diff) * {32'd0, cal_mpt};
        lo = (m & 64'hFFFFFF) * {40'd0, cal_iwb};
        t  = (m >> 24) * {40'd0, cal_iwb} + (lo >> 24);
        q  = (t >> 8) + ((t >> 7) & 64'd1);
        if (q > longint'(pi_ang))
        begin
            q = pi_ang;
        end
        dth = diff < 0 ? -longint'(q) : longint'(q);
        rotate(pose_h + (dth >>> 1), c, s);
        pose_x = sat32(pose_x + ((d * c + (64'sd1 <<< 29)) >>> 30));
        pose_y = sat32(pose_y + ((d * s + (64'sd1 <<< 29)) >>> 30));
        pose_h = wrap_heading(pose_h + dth);
        p.x = pose_x[31:0];
        p.y = pose_y[31:0];
        p.h = pose_h[18:0];
        return p;
    endfunction

    task automatic apb_write(odo_reg_e idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_METERS_PER_TICK: cal_mpt = val;
            REG_INV_WHEEL_BASE:  cal_iwb = val[23:0];
            REG_RIGHT_POLARITY:  cal_rpol = val[0];
            REG_LEFT_POLARITY:   cal_lpol = val[0];
            REG_START_X:         pose_x = longint'(signed'(val));
            REG_START_Y:         pose_y = longint'(signed'(val));
            REG_START_HEADING:   pose_h = wrap_heading(longint'(signed'(val[18:0])));
            default: ;
        endcase
        @(posedge clk);
    endtask

    // hold off until the pipeline has drained
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pose_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_sample(shortint r, shortint l, bit typed, pose_t typed_pose);
        int    gap;
        pose_t p;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (samples_sent % 200 < 40)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {l, r};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        p = odo_predict(r, l);
        pose_q.push_back(typed ? typed_pose : p);
        samples_sent++;
    endtask

    function automatic pose_t mk_pose(int x, int y, int h);
        pose_t p;
        p.x = x;
        p.y = y;
        p.h = h[18:0];
        return p;
    endfunction

    // receiver with random back-pressure
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (poses_seen % 300 < 50)
            begin
                gap = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (m_tvalid && m_tready)
        begin
            poses_seen++;
            if (pose_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pose x=%0d y=%0d h=%0d", $time,
                         $signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
                         $signed(m_tdata[82:64]));
            end
            else
            begin
                e = pose_q.pop_front();
                if (m_tdata[31:0] !== e.x)
                begin
                    errors++;
                    $display("%0t: pos_x expected %0d actual %0d", $time, e.x,
                             $signed(m_tdata[31:0]));
                end
                if (m_tdata[63:32] !== e.y)
                begin
                    errors++;
                    $display("%0t: pos_y expected %0d actual %0d", $time, e.y,
                             $signed(m_tdata[63:32]));
                end
                if (m_tdata[82:64] !== e.h)
                begin
                    errors++;
                    $display("%0t: heading_out expected %0d actual %0d", $time,
                             $signed(e.h), $signed(m_tdata[82:64]));
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d poses outstanding", $time, pose_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        odo_row_t dir_rows[$];
        odo_row_t row;
        shortint  r;
        shortint  l;
        int       mode;
        int       cnt;

        init_math();
        cal_mpt = '0;
        cal_iwb = '0;
        cal_rpol = 0;
        cal_lpol = 0;
        pose_x = 0;
        pose_y = 0;
        pose_h = 0;

        // out of reset: zero calibration, so no motion at all
        dir_rows.push_back('{0, REG_START_X, 0, 32767, -32768, 1, mk_pose(0, 0, 0)});
        dir_rows.push_back('{0, REG_START_X, 0, -32768, 32767, 1, mk_pose(0, 0, 0)});
        // start heading beyond +pi and below -pi wraps by 2*pi, then start x and y load as written
        dir_rows.push_back('{1, REG_START_HEADING, 32'h3FFFF, 0, 0, 1,
                             mk_pose(0, 0, -149631)});
        dir_rows.push_back('{1, REG_START_HEADING, 32'h40000, 0, 0, 1,
                             mk_pose(0, 0, 149630)});
        dir_rows.push_back('{1, REG_START_X, 32'h7FFFFFFF, 1, 1, 1,
                             mk_pose(32'h7FFFFFFF, 0, 149630)});
        dir_rows.push_back('{1, REG_START_Y, 32'h80000000, -1, -1, 1,
                             mk_pose(32'h7FFFFFFF, 32'h80000000, 149630)});
        // full scale calibration: saturation and clamped turn rate; then a smaller calibration
        dir_rows.push_back('{1, REG_METERS_PER_TICK, 32'hFFFFFFFF, 32767, 32767, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_INV_WHEEL_BASE, 32'hFFFFFF, 32767, -32768, 0, '{0, 0, 0}});
        dir_rows.push_back('{0, REG_START_X, 0, -32768, -32768, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_START_HEADING, 32'd205887, 32767, 32767, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_START_HEADING, 32'h7CBC1, -32768, -32768, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_RIGHT_POLARITY, 1, 32767, 32767, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_LEFT_POLARITY, 1, -32768, 32767, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_START_X, 32'h80000000, 0, 0, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_METERS_PER_TICK, 32'h00100000, 21845, -10923, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_INV_WHEEL_BASE, 32'h20000, 1, -1, 0, '{0, 0, 0}});
        dir_rows.push_back('{0, REG_START_X, 0, 100, 100, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_RIGHT_POLARITY, 0, -300, 300, 0, '{0, 0, 0}});
        dir_rows.push_back('{1, REG_LEFT_POLARITY, 0, 2000, -2000, 0, '{0, 0, 0}});
        dir_rows.push_back('{0, REG_START_X, 0, 1, 0, 0, '{0, 0, 0}});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.wr)
            begin
                wait_drained();
                apb_write(row.idx, row.val);
            end
            send_sample(row.r, row.l, row.typed, row.pose);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    apb_write(REG_METERS_PER_TICK, 32'hFFFFFFFF);
                    apb_write(REG_INV_WHEEL_BASE, 32'hFFFFFF);
                end
                1:
                begin
                    apb_write(REG_METERS_PER_TICK, 32'd0);
                    apb_write(REG_INV_WHEEL_BASE, 32'd0);
                end
                2:
                begin
                    apb_write(REG_METERS_PER_TICK, $urandom);
                    apb_write(REG_INV_WHEEL_BASE, $urandom_range(0, 24'hFFFFFF));
                end
                default:
                begin
                    apb_write(REG_METERS_PER_TICK, $urandom_range(1 << 16, 1 << 24));
                    apb_write(REG_INV_WHEEL_BASE, $urandom_range(1 << 16, 1 << 19));
                end
            endcase
            apb_write(REG_RIGHT_POLARITY, $urandom_range(0, 1));
            apb_write(REG_LEFT_POLARITY, $urandom_range(0, 1));
            apb_write(REG_START_X, (ph % 3 == 0) ? $urandom : $urandom_range(0, 1 << 20));
            apb_write(REG_START_Y, (ph % 3 == 1) ? $urandom : $urandom_range(0, 1 << 20));
            apb_write(REG_START_HEADING, $urandom);
            cnt = 0;
            while (cnt < ITEMS_PER_PHASE)
            begin
                mode = $urandom_range(0, 19);
                if (mode < 10)
                begin
                    r = shortint'($urandom_range(0, 400)) - 200;
                    l = r + shortint'($urandom_range(0, 40)) - 20;
                end
                else if (mode < 14)
                begin
                    r = shortint'($urandom);
                    l = shortint'($urandom);
                end
                else if (mode < 17)
                begin
                    r = shortint'($urandom_range(0, 2000)) - 1000;
                    l = r;
                end
                else
                begin
                    r = shortint'($urandom_range(0, 2000)) - 1000;
                    l = -r;
                end
                if (ph == 3 && cnt == 100)
                begin
                    wait_drained();
                end
                send_sample(r, l, 0, '{0, 0, 0});
                cnt++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pose_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d samples and %0d poses over %0d calibration phases,",
                 samples_sent, poses_seen, RAND_PHASES);
        $display("including start wrap, saturation and full-scale deltas.");
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/dd_odo_pkg.sv
rtl/core/dd_odo_cordic_cell.sv
rtl/core/dd_odo_cordic.sv
rtl/core/diff_drive_odometry.sv
tb/tb_diff_drive_odometry.sv
